### rtl/fpsu_pkg.sv
// Package: types, codes and helper functions for the frame pointer stack unwinder.
`default_nettype none

package fpsu_pkg;

   localparam int unsigned ADDR_W        = 64;
   localparam int unsigned INDEX_W       = 16;
   localparam int unsigned DIST_W        = 32;
   localparam int unsigned CSR_INDEX_W   = 1;
   localparam int unsigned CSR_DATA_W    = 32;
   localparam int unsigned CANON_LSB     = 47;
   localparam int unsigned ALIGN_BITS    = 3;

   localparam logic [INDEX_W-1:0] MAX_FRAMES_RESET   = 16'd64;
   localparam logic [DIST_W-1:0]  MAX_DISTANCE_RESET = 32'd1048576;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_FRAMES   = 1'b0,
      CSR_MAX_DISTANCE = 1'b1
   } csr_index_type;

   typedef enum logic {
      FUNC_START = 1'b0,
      FUNC_RESP  = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      ACT_READ    = 2'd0,
      ACT_DONE    = 2'd1,
      ACT_FAIL    = 2'd2,
      ACT_IGNORED = 2'd3
   } action_type;

   typedef struct packed {
      func_type          func;
      logic [ADDR_W-1:0] start_ip;
      logic [ADDR_W-1:0] start_fp;
      logic [ADDR_W-1:0] saved_fp;
      logic [ADDR_W-1:0] saved_ret;
      logic              read_ok;
   } req_type;

   typedef struct packed {
      logic               frame_emitted;
      logic [INDEX_W-1:0] frame_index;
      logic [ADDR_W-1:0]  instr_ptr;
      logic [ADDR_W-1:0]  frame_ptr;
      logic [ADDR_W-1:0]  return_addr;
      logic               is_current;
      action_type         next_action;
      logic [ADDR_W-1:0]  read_addr;
   } rsp_type;

   typedef struct packed {
      logic               walking;
      logic               load_ptr;
      logic [ADDR_W-1:0]  fp;
      logic [INDEX_W-1:0] index;
   } walk_upd_type;

   function automatic logic canonical48(input logic [ADDR_W-1:0] a);
      return (&a[ADDR_W-1:CANON_LSB]) | ~(|a[ADDR_W-1:CANON_LSB]);
   endfunction

   function automatic logic pointer_usable(input logic [ADDR_W-1:0] p);
      return (|p) && canonical48(p) && ~(|p[ALIGN_BITS-1:0]);
   endfunction

endpackage

`default_nettype wire

### rtl/fpsu_req_if.sv
// Interface: request channel carrying start items and memory read responses.
`default_nettype none

interface fpsu_req_if import fpsu_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/fpsu_rsp_if.sv
// Interface: response channel carrying frame records and next actions.
`default_nettype none

interface fpsu_rsp_if import fpsu_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/fpsu_eval.sv
// Frame evaluation: checks one item against the walk state and forms result and state update.
`default_nettype none

module fpsu_eval import fpsu_pkg::*; (
   input  req_type             item,
   input  logic                walking,
   input  logic [ADDR_W-1:0]   cur_fp,
   input  logic [INDEX_W-1:0]  next_index,
   input  logic [INDEX_W-1:0]  max_frames,
   input  logic [DIST_W-1:0]   max_distance,
   output rsp_type             rsp,
   output walk_upd_type        upd
);

   logic [ADDR_W-1:0]  plan_fp;
   logic [INDEX_W:0]   plan_idx;
   logic [ADDR_W-1:0]  step;
   logic               step_ok;
   logic               plan_ok;
   logic               do_plan;

   always_comb begin
      step    = item.saved_fp - cur_fp;
      step_ok = pointer_usable(item.saved_fp) && (item.saved_fp > cur_fp)
                && ~(|step[ADDR_W-1:DIST_W]) && (step[DIST_W-1:0] <= max_distance);
   end

   always_comb begin
      rsp        = '0;
      upd        = '0;
      upd.walking = walking;
      do_plan    = 1'b0;
      plan_fp    = item.saved_fp;
      plan_idx   = {1'b0, next_index} + {{INDEX_W{1'b0}}, 1'b1};

      if (item.func == FUNC_START) begin
         if (!item.read_ok) begin
            upd.walking     = 1'b0;
            rsp.next_action = ACT_FAIL;
         end else begin
            rsp.frame_emitted = 1'b1;
            rsp.instr_ptr     = item.start_ip;
            rsp.frame_ptr     = item.start_fp;
            rsp.is_current    = 1'b1;
            do_plan           = 1'b1;
            plan_fp           = item.start_fp;
            plan_idx          = {{INDEX_W{1'b0}}, 1'b1};
         end
      end else if (!walking) begin
         rsp.next_action = ACT_IGNORED;
      end else if (!item.read_ok || !canonical48(item.saved_ret)) begin
         upd.walking     = 1'b0;
         rsp.next_action = ACT_DONE;
      end else begin
         rsp.frame_emitted = 1'b1;
         rsp.frame_index   = next_index;
         rsp.instr_ptr     = item.saved_ret;
         rsp.frame_ptr     = cur_fp;
         rsp.return_addr   = item.saved_ret;
         if (!step_ok) begin
            upd.walking     = 1'b0;
            rsp.next_action = ACT_DONE;
         end else begin
            do_plan = 1'b1;
         end
      end

      plan_ok = (plan_idx < {1'b0, max_frames}) && pointer_usable(plan_fp);
      if (do_plan) begin
         if (plan_ok) begin
            upd.walking     = 1'b1;
            upd.load_ptr    = 1'b1;
            rsp.next_action = ACT_READ;
            rsp.read_addr   = plan_fp;
         end else begin
            upd.walking     = 1'b0;
            rsp.next_action = ACT_DONE;
         end
      end
      upd.fp    = plan_fp;
      upd.index = plan_idx[INDEX_W-1:0];
   end

endmodule

`default_nettype wire

### rtl/frame_pointer_stack_unwinder_unit.sv
// Top level: x86-64 frame pointer chain unwinder with input and result registers.
//
// Takes one item per cycle, start or memory response, unless the output stalls,
// and returns exactly one result for each. Items pass an input
// register, one evaluation stage of canonical, alignment and distance compares,
// and a result register; the walk state updates when the result register loads,
// so the next item already sees it. The memory read latency outside the block
// sets how fast a chain is walked. req_bus.ready follows rsp_bus.ready
// combinationally when both registers are full. Configuration writes take effect
// on the next cycle and must only be made while no item is in flight.
`default_nettype none

module frame_pointer_stack_unwinder_unit import fpsu_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   fpsu_req_if.sink               req_bus,
   fpsu_rsp_if.source             rsp_bus,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic               in_valid_ff;
   req_type            in_item_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;
   logic               walking_ff, walking_in;
   logic [ADDR_W-1:0]  cur_fp_ff, cur_fp_in;
   logic [INDEX_W-1:0] next_index_ff, next_index_in;
   logic [INDEX_W-1:0] max_frames_ff;
   logic [DIST_W-1:0]  max_distance_ff;

   rsp_type            eval_rsp;
   walk_upd_type       eval_upd;
   logic               out_load;
   logic               in_load;

   assign out_load      = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign in_load       = !in_valid_ff || out_load;
   assign req_bus.ready = in_load;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.payload = rsp_data_ff;

   fpsu_eval u_eval (
      .item         (in_item_ff),
      .walking      (walking_ff),
      .cur_fp       (cur_fp_ff),
      .next_index   (next_index_ff),
      .max_frames   (max_frames_ff),
      .max_distance (max_distance_ff),
      .rsp          (eval_rsp),
      .upd          (eval_upd)
   );

   always_comb begin
      walking_in    = walking_ff;
      cur_fp_in     = cur_fp_ff;
      next_index_in = next_index_ff;
      if (out_load) begin
         walking_in = eval_upd.walking;
         if (eval_upd.load_ptr) begin
            cur_fp_in     = eval_upd.fp;
            next_index_in = eval_upd.index;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         walking_ff      <= 1'b0;
         cur_fp_ff       <= '0;
         next_index_ff   <= '0;
         max_frames_ff   <= MAX_FRAMES_RESET;
         max_distance_ff <= MAX_DISTANCE_RESET;
      end else begin
         if (in_load) begin
            in_valid_ff <= req_bus.valid;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         walking_ff    <= walking_in;
         cur_fp_ff     <= cur_fp_in;
         next_index_ff <= next_index_in;
         if (csr_wr_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_MAX_FRAMES:   max_frames_ff   <= csr_wdata[INDEX_W-1:0];
               CSR_MAX_DISTANCE: max_distance_ff <= csr_wdata[DIST_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_bus.valid) begin
         in_item_ff <= req_bus.payload;
      end
      if (out_load) begin
         rsp_data_ff <= eval_rsp;
      end
   end

endmodule

`default_nettype wire

### rtl/fpsu_checker.sv
// Checker: port-level assertions for the unwinder, bound to the top level.
`default_nettype none

module fpsu_checker import fpsu_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_addr_only_on_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.next_action != ACT_READ) |-> rsp_payload.read_addr == '0)
      else $error("read address without read request");

   a_no_frame_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.frame_emitted
      |-> rsp_payload.frame_index == '0 && !rsp_payload.is_current
          && rsp_payload.instr_ptr == '0 && rsp_payload.return_addr == '0)
      else $error("frame fields set without a frame");

   a_current_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.is_current
      |-> rsp_payload.frame_emitted && rsp_payload.frame_index == '0
          && rsp_payload.return_addr == '0)
      else $error("malformed current frame");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

endmodule

bind frame_pointer_stack_unwinder_unit fpsu_checker u_fpsu_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_payload (rsp_bus.payload)
);

`default_nettype wire
